/* hw/rtl/lnct_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lnct_pkg;

   localparam int NodeW = 12;
   localparam int FuncW = 2;
   localparam int RhsW  = 4;
   localparam int CatW  = 3;
   localparam int MaskW = 12;

   typedef logic [FuncW-1:0] func_type;
   typedef logic [CatW-1:0]  cat_type;

   localparam func_type FUNC_UPD_DEP    = 2'd0;
   localparam func_type FUNC_UPD_NONDEP = 2'd1;
   localparam func_type FUNC_QRY_SUB    = 2'd2;
   localparam func_type FUNC_QRY_SUP    = 2'd3;

   localparam cat_type CAT_UNOBSERVED      = 3'd0;
   localparam cat_type CAT_MIN_DEP         = 3'd1;
   localparam cat_type CAT_DEP             = 3'd2;
   localparam cat_type CAT_CAND_MIN_DEP    = 3'd3;
   localparam cat_type CAT_MAX_NONDEP      = 3'd4;
   localparam cat_type CAT_NONDEP          = 3'd5;
   localparam cat_type CAT_CAND_MAX_NONDEP = 3'd6;

   typedef struct packed {
      logic     clear;
      logic     self_valid;
      logic     nbr_valid;
      logic     nbr_rel;
      func_type func;
   } acc_ctl_type;

   typedef struct packed {
      cat_type self_cat;
      logic    hit;
      logic    unobs;
   } acc_stat_type;

   function automatic logic is_superset_func(func_type func);
      return (func == FUNC_UPD_NONDEP) || (func == FUNC_QRY_SUP);
   endfunction

   function automatic logic is_cand(cat_type c);
      return (c == CAT_CAND_MIN_DEP) || (c == CAT_CAND_MAX_NONDEP);
   endfunction

   function automatic cat_type result_cat(func_type func, logic single, acc_stat_type st);
      cat_type c;
      case (func)
         FUNC_UPD_DEP: begin
            if (single)
               c = CAT_MIN_DEP;
            else if (st.hit)
               c = CAT_DEP;
            else if (st.unobs)
               c = CAT_CAND_MIN_DEP;
            else
               c = CAT_MIN_DEP;
         end
         FUNC_UPD_NONDEP: begin
            if (st.hit)
               c = CAT_NONDEP;
            else if (st.unobs)
               c = CAT_CAND_MAX_NONDEP;
            else
               c = CAT_MAX_NONDEP;
         end
         default: c = st.self_cat;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/lnct_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module lnct_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 4096,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/lnct_nbr.sv */
`timescale 1ns / 1ps
`default_nettype none

module lnct_nbr #(
   parameter int NUM_COLUMNS = 12,
   localparam int ColW = $clog2(NUM_COLUMNS)
) (
   input  wire logic [NUM_COLUMNS-1:0]    node,
   input  wire logic [ColW-1:0]           col,
   input  wire lnct_pkg::func_type        func,
   input  wire logic [lnct_pkg::RhsW-1:0] rhs_col,
   output logic      [NUM_COLUMNS-1:0]    addr,
   output logic                           relevant
);
   import lnct_pkg::*;

   logic [NUM_COLUMNS-1:0] bit_sel;
   logic                   in_node;
   logic                   rhs_hit;

   always_comb begin
      bit_sel  = {{(NUM_COLUMNS-1){1'b0}}, 1'b1} << col;
      in_node  = |(node & bit_sel);
      rhs_hit  = (32'(rhs_col) < NUM_COLUMNS) && (32'(col) == 32'(rhs_col));
      addr     = node ^ bit_sel;
      relevant = is_superset_func(func) ? (!in_node && !rhs_hit) : in_node;
   end

endmodule

`default_nettype wire

/* hw/rtl/lnct_accum.sv */
`timescale 1ns / 1ps
`default_nettype none

module lnct_accum #(
   parameter int NUM_COLUMNS = 12,
   localparam int ColW = $clog2(NUM_COLUMNS)
) (
   input  wire logic                    clock,
   input  wire lnct_pkg::acc_ctl_type   ctl,
   input  wire logic [ColW-1:0]         col,
   input  wire lnct_pkg::cat_type       rd_cat,
   output lnct_pkg::acc_stat_type       stat,
   output logic [NUM_COLUMNS-1:0]       mask
);
   import lnct_pkg::*;

   cat_type                self_cat_ff, self_cat_in;
   logic                   hit_ff, hit_in;
   logic                   unobs_ff, unobs_in;
   logic [NUM_COLUMNS-1:0] mask_ff, mask_in;
   logic                   deplike;
   logic                   unobs_now;

   always_comb begin
      if (is_superset_func(ctl.func))
         deplike = (rd_cat == CAT_MAX_NONDEP) || (rd_cat == CAT_NONDEP) ||
                   (rd_cat == CAT_CAND_MAX_NONDEP);
      else
         deplike = (rd_cat == CAT_MIN_DEP) || (rd_cat == CAT_DEP) ||
                   (rd_cat == CAT_CAND_MIN_DEP);
      unobs_now = (rd_cat == CAT_UNOBSERVED);

      self_cat_in = self_cat_ff;
      hit_in      = hit_ff;
      unobs_in    = unobs_ff;
      mask_in     = mask_ff;
      if (ctl.clear) begin
         self_cat_in = CAT_UNOBSERVED;
         hit_in      = 1'b0;
         unobs_in    = 1'b0;
         mask_in     = '0;
      end else begin
         if (ctl.self_valid)
            self_cat_in = rd_cat;
         if (ctl.nbr_valid && ctl.nbr_rel) begin
            if (unobs_now) begin
               unobs_in = 1'b1;
               mask_in  = mask_ff | ({{(NUM_COLUMNS-1){1'b0}}, 1'b1} << col);
            end
            if (deplike)
               hit_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      self_cat_ff <= self_cat_in;
      hit_ff      <= hit_in;
      unobs_ff    <= unobs_in;
      mask_ff     <= mask_in;
   end

   assign stat.self_cat = self_cat_ff;
   assign stat.hit      = hit_ff;
   assign stat.unobs    = unobs_ff;
   assign mask          = mask_ff;

endmodule

`default_nettype wire

/* hw/rtl/lattice_node_category_table.sv */
// Category table for a column-set lattice of NUM_COLUMNS columns, one 3-bit code per node,
// held in a 2**NUM_COLUMNS entry RAM. After reset the block sweeps the RAM to unobserved,
// one entry a cycle, and holds req_stall high until the sweep is done. For each item the
// read of the node itself is issued at the accept, then one neighbor read per column goes
// through the single RAM read port, a drain state lets the last read return and a write
// state folds the flags into the category and writes it back. One item is in flight at a
// time; the next is taken while the previous result waits on rsp_stall. Node bits
// at or above NUM_COLUMNS are ignored and only the low 12 bits of the unchecked mask are
// reported; update items report a zero mask.
`timescale 1ns / 1ps
`default_nettype none

module lattice_node_category_table #(
   parameter int NUM_COLUMNS = 12
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [lnct_pkg::FuncW-1:0]     req_func,
   input  wire logic [lnct_pkg::NodeW-1:0]     req_node,
   input  wire logic [lnct_pkg::RhsW-1:0]      req_rhs_col,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [lnct_pkg::CatW-1:0]           rsp_category,
   output logic                                rsp_is_candidate,
   output logic [lnct_pkg::MaskW-1:0]          rsp_unchecked_mask
);
   import lnct_pkg::*;

   localparam int Depth = 2 ** NUM_COLUMNS;
   localparam int ColW  = $clog2(NUM_COLUMNS);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_WRITE = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0]             state_ff, state_in;
   logic [NUM_COLUMNS-1:0] clr_ff, clr_in;
   logic [ColW-1:0]        col_ff, col_in;
   func_type               func_ff, func_in;
   logic [NUM_COLUMNS-1:0] node_ff, node_in;
   logic [RhsW-1:0]        rhs_ff, rhs_in;

   logic                   rd_self_ff, rd_self_in;
   logic                   rd_nbr_ff, rd_nbr_in;
   logic                   rd_rel_ff, rd_rel_in;
   logic [ColW-1:0]        rd_col_ff, rd_col_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   cat_type                rsp_cat_ff, rsp_cat_in;
   logic                   rsp_cand_ff, rsp_cand_in;
   logic [MaskW-1:0]       rsp_mask_ff, rsp_mask_in;

   logic                   accept;
   logic                   load_out;
   logic                   is_update;
   logic                   single;
   logic [31:0]            req_node_wide;
   logic [31:0]            mask_wide;
   cat_type                res_cat;

   logic [NUM_COLUMNS-1:0] nbr_addr;
   logic                   nbr_rel;

   logic                   ram_we;
   logic [NUM_COLUMNS-1:0] ram_waddr;
   cat_type                ram_wdata;
   logic [NUM_COLUMNS-1:0] ram_raddr;
   cat_type                ram_rdata;

   acc_ctl_type            acc_ctl;
   acc_stat_type           acc_stat;
   logic [NUM_COLUMNS-1:0] acc_mask;

   lnct_nbr #(.NUM_COLUMNS(NUM_COLUMNS)) u_nbr (
      .node      (node_ff),
      .col       (col_ff),
      .func      (func_ff),
      .rhs_col   (rhs_ff),
      .addr      (nbr_addr),
      .relevant  (nbr_rel)
   );

   lnct_ram #(.WIDTH(CatW), .DEPTH(Depth)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   lnct_accum #(.NUM_COLUMNS(NUM_COLUMNS)) u_accum (
      .clock  (clock),
      .ctl    (acc_ctl),
      .col    (rd_col_ff),
      .rd_cat (ram_rdata),
      .stat   (acc_stat),
      .mask   (acc_mask)
   );

   always_comb begin
      req_stall     = (state_ff != S_IDLE);
      accept        = req_valid && (state_ff == S_IDLE);
      req_node_wide = 32'(req_node);
      is_update     = (func_ff == FUNC_UPD_DEP) || (func_ff == FUNC_UPD_NONDEP);
      single        = ((node_ff & (node_ff - NUM_COLUMNS'(1))) == '0);
      res_cat       = result_cat(func_ff, single, acc_stat);
      mask_wide     = 32'(acc_mask);
      load_out      = ((state_ff == S_WRITE) || (state_ff == S_OUT)) &&
                      (!rsp_valid_ff || !rsp_stall);

      acc_ctl.clear      = accept;
      acc_ctl.self_valid = rd_self_ff;
      acc_ctl.nbr_valid  = rd_nbr_ff;
      acc_ctl.nbr_rel    = rd_rel_ff;
      acc_ctl.func       = func_ff;

      ram_we    = (state_ff == S_CLEAR) || ((state_ff == S_WRITE) && is_update);
      ram_waddr = (state_ff == S_CLEAR) ? clr_ff : node_ff;
      ram_wdata = (state_ff == S_CLEAR) ? CAT_UNOBSERVED : res_cat;
      ram_raddr = accept ? req_node_wide[NUM_COLUMNS-1:0] : nbr_addr;

      state_in   = state_ff;
      clr_in     = clr_ff;
      col_in     = col_ff;
      func_in    = func_ff;
      node_in    = node_ff;
      rhs_in     = rhs_ff;
      rd_self_in = accept;
      rd_nbr_in  = (state_ff == S_SCAN);
      rd_rel_in  = nbr_rel;
      rd_col_in  = col_ff;

      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + NUM_COLUMNS'(1);
            if (&clr_ff)
               state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               func_in  = req_func;
               node_in  = req_node_wide[NUM_COLUMNS-1:0];
               rhs_in   = req_rhs_col;
               col_in   = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            col_in = col_ff + ColW'(1);
            if (col_ff == ColW'(NUM_COLUMNS - 1))
               state_in = S_DRAIN;
         end
         S_DRAIN: state_in = S_WRITE;
         S_WRITE: state_in = load_out ? S_IDLE : S_OUT;
         S_OUT: begin
            if (load_out)
               state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_cat_in   = rsp_cat_ff;
      rsp_cand_in  = rsp_cand_ff;
      rsp_mask_in  = rsp_mask_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_cat_in   = res_cat;
         rsp_cand_in  = is_cand(res_cat);
         rsp_mask_in  = is_update ? '0 : mask_wide[MaskW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rd_self_ff   <= 1'b0;
         rd_nbr_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rd_self_ff   <= rd_self_in;
         rd_nbr_ff    <= rd_nbr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      col_ff      <= col_in;
      func_ff     <= func_in;
      node_ff     <= node_in;
      rhs_ff      <= rhs_in;
      rd_rel_ff   <= rd_rel_in;
      rd_col_ff   <= rd_col_in;
      rsp_cat_ff  <= rsp_cat_in;
      rsp_cand_ff <= rsp_cand_in;
      rsp_mask_ff <= rsp_mask_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_category       = rsp_cat_ff;
   assign rsp_is_candidate   = rsp_cand_ff;
   assign rsp_unchecked_mask = rsp_mask_ff;

`ifndef NO_ASSERTIONS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("block not busy after accepting a beat");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == S_WRITE || $past(state_ff) == S_OUT))
      else $error("result beat raised outside finish states");

   a_write_source: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_CLEAR ||
                  (state_ff == S_WRITE &&
                   (func_ff == FUNC_UPD_DEP || func_ff == FUNC_UPD_NONDEP))))
      else $error("table written outside clear or update write-back");
`endif

endmodule

`default_nettype wire

/* dv/node_category_checker.sv */
`timescale 1ns / 1ps

module node_category_checker #(
   parameter int NUM_COLUMNS = 12
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_stall,
   input  wire logic [lnct_pkg::FuncW-1:0] req_func,
   input  wire logic [lnct_pkg::NodeW-1:0] req_node,
   input  wire logic [lnct_pkg::RhsW-1:0]  req_rhs_col,
   input  wire logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   input  wire logic [lnct_pkg::CatW-1:0]  rsp_category,
   input  wire logic                       rsp_is_candidate,
   input  wire logic [lnct_pkg::MaskW-1:0] rsp_unchecked_mask,
   output int                              fail_count,
   output int                              pending_count
);
   import lnct_pkg::*;

   localparam int Depth = 1 << NUM_COLUMNS;
   localparam logic [NodeW-1:0] LatticeMask = NodeW'(Depth - 1);

   typedef struct packed {
      cat_type          category;
      logic             is_candidate;
      logic [MaskW-1:0] unchecked_mask;
   } answer_type;

   cat_type    node_categories [Depth];
   answer_type pending_answers [$];

   function automatic logic [NodeW-1:0] superset_columns(logic [NodeW-1:0] node,
                                                         logic [RhsW-1:0] rhs);
      logic [NodeW-1:0] cols;
      cols = ~node & LatticeMask;
      if (rhs < NUM_COLUMNS)
         cols[rhs] = 1'b0;
      return cols;
   endfunction

   function automatic logic [MaskW-1:0] unobserved_toggles(logic [NodeW-1:0] node,
                                                           logic [NodeW-1:0] cols);
      logic [MaskW-1:0] found;
      logic [NodeW-1:0] bit_i;
      found = '0;
      for (int i = 0; i < NUM_COLUMNS; i++) begin
         bit_i = NodeW'(1) << i;
         if (cols[i] && i < MaskW &&
             node_categories[(node ^ bit_i) & LatticeMask] == CAT_UNOBSERVED)
            found[i] = 1'b1;
      end
      return found;
   endfunction

   function automatic cat_type classify_dep(logic [NodeW-1:0] node);
      logic             hit;
      logic             unobs;
      cat_type          c;
      logic [NodeW-1:0] bit_i;
      hit = 1'b0;
      unobs = 1'b0;
      if ($countones(node) <= 1)
         return CAT_MIN_DEP;
      for (int i = 0; i < NUM_COLUMNS; i++) begin
         bit_i = NodeW'(1) << i;
         if (node[i]) begin
            c = node_categories[node & ~bit_i];
            if (c == CAT_UNOBSERVED)
               unobs = 1'b1;
            else if (c == CAT_MIN_DEP || c == CAT_DEP || c == CAT_CAND_MIN_DEP)
               hit = 1'b1;
         end
      end
      if (hit)
         return CAT_DEP;
      return unobs ? CAT_CAND_MIN_DEP : CAT_MIN_DEP;
   endfunction

   function automatic cat_type classify_nondep(logic [NodeW-1:0] node, logic [RhsW-1:0] rhs);
      logic             hit;
      logic             unobs;
      cat_type          c;
      logic [NodeW-1:0] cols;
      logic [NodeW-1:0] bit_i;
      hit = 1'b0;
      unobs = 1'b0;
      cols = superset_columns(node, rhs);
      for (int i = 0; i < NUM_COLUMNS; i++) begin
         bit_i = NodeW'(1) << i;
         if (cols[i]) begin
            c = node_categories[(node | bit_i) & LatticeMask];
            if (c == CAT_UNOBSERVED)
               unobs = 1'b1;
            else if (c == CAT_MAX_NONDEP || c == CAT_NONDEP || c == CAT_CAND_MAX_NONDEP)
               hit = 1'b1;
         end
      end
      if (hit)
         return CAT_NONDEP;
      return unobs ? CAT_CAND_MAX_NONDEP : CAT_MAX_NONDEP;
   endfunction

   function automatic answer_type predict_answer(func_type f, logic [NodeW-1:0] raw_node,
                                                 logic [RhsW-1:0] rhs);
      answer_type       a;
      logic [NodeW-1:0] node;
      node = raw_node & LatticeMask;
      a.unchecked_mask = '0;
      case (f)
         FUNC_UPD_DEP: begin
            a.category = classify_dep(node);
            node_categories[node] = a.category;
         end
         FUNC_UPD_NONDEP: begin
            a.category = classify_nondep(node, rhs);
            node_categories[node] = a.category;
         end
         FUNC_QRY_SUB: begin
            a.category = node_categories[node];
            a.unchecked_mask = unobserved_toggles(node, node);
         end
         default: begin
            a.category = node_categories[node];
            a.unchecked_mask = unobserved_toggles(node, superset_columns(node, rhs));
         end
      endcase
      a.is_candidate = (a.category == CAT_CAND_MIN_DEP) ||
                       (a.category == CAT_CAND_MAX_NONDEP);
      return a;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      int         errs;
      errs = 0;
      if (reset) begin
         for (int i = 0; i < Depth; i++)
            node_categories[i] = CAT_UNOBSERVED;
         pending_answers.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_answers.size() == 0) begin
               $error("unexpected result beat: category %0d mask %h",
                      rsp_category, rsp_unchecked_mask);
               errs++;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_category !== want.category) begin
                  $error("rsp_category: expected %0d, actual %0d",
                         want.category, rsp_category);
                  errs++;
               end
               if (rsp_is_candidate !== want.is_candidate) begin
                  $error("rsp_is_candidate: expected %0d, actual %0d",
                         want.is_candidate, rsp_is_candidate);
                  errs++;
               end
               if (rsp_unchecked_mask !== want.unchecked_mask) begin
                  $error("rsp_unchecked_mask: expected %h, actual %h",
                         want.unchecked_mask, rsp_unchecked_mask);
                  errs++;
               end
            end
         end
         if (req_valid && !req_stall)
            pending_answers.push_back(predict_answer(req_func, req_node, req_rhs_col));
      end
      fail_count <= fail_count + errs;
      pending_count <= pending_answers.size();
   end

endmodule

/* dv/tb_lattice_node_category_table.sv */
`timescale 1ns / 1ps

module tb_lattice_node_category_table;
   import lnct_pkg::*;

   localparam int NUM_COLUMNS  = 12;
   localparam int RANDOM_ITEMS = 1300;
   localparam int CYCLE_LIMIT  = 400000;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   func_type             req_func = FUNC_QRY_SUB;
   logic [NodeW-1:0]     req_node = '0;
   logic [RhsW-1:0]      req_rhs_col = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [CatW-1:0]      rsp_category;
   logic                 rsp_is_candidate;
   logic [MaskW-1:0]     rsp_unchecked_mask;

   int fail_count;
   int pending_count;
   int cycle_count = 0;
   int burst_left = 0;
   int stall_mode = 0;
   int stall_phase = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   lattice_node_category_table #(.NUM_COLUMNS(NUM_COLUMNS)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_node           (req_node),
      .req_rhs_col        (req_rhs_col),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_category       (rsp_category),
      .rsp_is_candidate   (rsp_is_candidate),
      .rsp_unchecked_mask (rsp_unchecked_mask)
   );

   node_category_checker #(.NUM_COLUMNS(NUM_COLUMNS)) category_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_node           (req_node),
      .req_rhs_col        (req_rhs_col),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_category       (rsp_category),
      .rsp_is_candidate   (rsp_is_candidate),
      .rsp_unchecked_mask (rsp_unchecked_mask),
      .fail_count         (fail_count),
      .pending_count      (pending_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_lattice_node_category_table: FAIL");
         $finish;
      end
   end

   // result-side backpressure: the mode is redrawn at random whenever its phase counter runs out
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_phase == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_phase = $urandom_range(20, 200);
         end
         stall_phase = stall_phase - 1;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= $urandom_range(0, 1);
            default: rsp_stall <= ((stall_phase % 16) < 11);
         endcase
      end
   end

   task automatic send_beat(func_type f, logic [NodeW-1:0] n, logic [RhsW-1:0] r);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left = burst_left - 1;
      req_valid <= 1'b1;
      req_func <= f;
      req_node <= n;
      req_rhs_col <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   function automatic logic [NodeW-1:0] pick_universe();
      logic [NodeW-1:0] u;
      int               want;
      u = '0;
      want = $urandom_range(2, 6);
      while ($countones(u) < want)
         u[$urandom_range(0, NodeW - 1)] = 1'b1;
      return u;
   endfunction

   initial begin
      logic [NodeW-1:0] universe;
      logic [NodeW-1:0] node;
      logic [NodeW-1:0] last_node;
      logic [RhsW-1:0]  rhs;
      func_type         f;
      int               sel;
      universe = '0;
      last_node = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_beat(FUNC_QRY_SUB, 12'h000, 4'd0);
      send_beat(FUNC_QRY_SUP, 12'h000, 4'd15);
      send_beat(FUNC_UPD_DEP, 12'h000, 4'd0);
      send_beat(FUNC_UPD_DEP, 12'h001, 4'd0);
      send_beat(FUNC_UPD_DEP, 12'h003, 4'd0);
      send_beat(FUNC_UPD_DEP, 12'h006, 4'd0);
      send_beat(FUNC_QRY_SUB, 12'h006, 4'd0);
      send_beat(FUNC_UPD_DEP, 12'h004, 4'd0);
      send_beat(FUNC_UPD_DEP, 12'h002, 4'd0);
      send_beat(FUNC_UPD_NONDEP, 12'h010, 4'd4);
      send_beat(FUNC_UPD_NONDEP, 12'h020, 4'd5);
      send_beat(FUNC_UPD_DEP, 12'h030, 4'd0);
      send_beat(FUNC_UPD_NONDEP, 12'hFFF, 4'd0);
      send_beat(FUNC_UPD_NONDEP, 12'h7FF, 4'd15);
      send_beat(FUNC_UPD_NONDEP, 12'hDFF, 4'd2);
      send_beat(FUNC_UPD_NONDEP, 12'hEFF, 4'd8);
      send_beat(FUNC_UPD_NONDEP, 12'h0F0, 4'd0);
      send_beat(FUNC_QRY_SUP, 12'h0F0, 4'd14);
      send_beat(FUNC_QRY_SUP, 12'h7FF, 4'd11);
      send_beat(FUNC_QRY_SUB, 12'hFFF, 4'd0);
      send_beat(FUNC_QRY_SUP, 12'hFFF, 4'd5);
      send_beat(FUNC_QRY_SUB, 12'hEFF, 4'd7);
      send_beat(FUNC_QRY_SUP, 12'h800, 4'd12);
      drain_results();

      // mostly walks inside small column subsets so neighbors get observed
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % 60 == 0)
            universe = pick_universe();
         if (k % 300 == 150)
            drain_results();
         sel = $urandom_range(0, 99);
         if (sel < 70)
            node = NodeW'($urandom) & universe;
         else if (sel < 85)
            node = last_node ^ (NodeW'(1) << $urandom_range(0, NodeW - 1));
         else
            node = NodeW'($urandom);
         case ($urandom_range(0, 9))
            0, 1, 2: f = FUNC_UPD_DEP;
            3, 4, 5: f = FUNC_UPD_NONDEP;
            6, 7:    f = FUNC_QRY_SUB;
            default: f = FUNC_QRY_SUP;
         endcase
         if ($urandom_range(0, 4) == 0)
            rhs = RhsW'($urandom_range(0, 15));
         else
            rhs = RhsW'($urandom_range(0, NUM_COLUMNS - 1));
         send_beat(f, node, rhs);
         last_node = node;
      end

      drain_results();
      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("tb_lattice_node_category_table: PASS");
      else
         $display("tb_lattice_node_category_table: FAIL");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/lnct_pkg.sv
hw/rtl/lnct_ram.sv
hw/rtl/lnct_nbr.sv
hw/rtl/lnct_accum.sv
hw/rtl/lattice_node_category_table.sv
dv/node_category_checker.sv
dv/tb_lattice_node_category_table.sv
